FILE: rtl/sstc_pkg.sv
// Shared types, constants and setting clamps for the scroll segment tier classifier.
// Used by every module of the block; it depends on nothing.
package sstc_pkg;

  // Register file layout
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HOT_SPAN  = 2'd0,
    CFG_WARM_SPAN = 2'd1,
    CFG_LOOKAHEAD = 2'd2,
    CFG_SPEED_CAP = 2'd3
  } cfg_idx_e;

  localparam logic [7:0]  HOT_RESET  = 8'd16;
  localparam logic [9:0]  WARM_RESET = 10'd128;
  localparam logic [11:0] MS_RESET   = 12'd100;
  localparam logic [15:0] CAP_RESET  = 16'd10000;

  typedef enum logic [1:0] {
    TIER_HOT  = 2'd0,
    TIER_WARM = 2'd1,
    TIER_COLD = 2'd2
  } tier_e;

  // Direction bias, 8 fractional bits
  localparam logic [8:0] BIAS_FWD  = 9'd346;
  localparam logic [8:0] BIAS_BACK = 9'd166;

  // floor(2^28 / 250): reciprocal for the divide by 250 in the forecast
  localparam logic [20:0] RECIP_250   = 21'd1073741;
  localparam logic [27:0] DIV_250     = 28'd250;
  localparam logic [27:0] ROUND_BIAS  = 28'd125;

  // Widening amounts, start side and end side of each range
  typedef struct packed {
    logic [25:0] hot_lo;
    logic [25:0] hot_hi;
    logic [25:0] warm_lo;
    logic [25:0] warm_hi;
  } widen_t;

  // Forecast pipe result
  typedef struct packed {
    logic        valid;
    logic [30:0] top;
    logic [31:0] fore;
  } fc_t;

  // Hot span, Q4.4 screens, limited to 0.5..8
  function automatic logic [7:0] clamp_hot(logic [7:0] v);
    logic [7:0] r;
    if (v < 8'd8) begin
      r = 8'd8;
    end else if (v > 8'd128) begin
      r = 8'd128;
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Warm span, Q6.4 screens, limited to 2..30
  function automatic logic [8:0] clamp_warm(logic [9:0] v);
    logic [8:0] r;
    if (v < 10'd32) begin
      r = 9'd32;
    end else if (v > 10'd480) begin
      r = 9'd480;
    end else begin
      r = v[8:0];
    end
    return r;
  endfunction

  // Lookahead, limited to one second
  function automatic logic [9:0] clamp_ms(logic [11:0] v);
    logic [9:0] r;
    if (v > 12'd1000) begin
      r = 10'd1000;
    end else begin
      r = v[9:0];
    end
    return r;
  endfunction

  // Speed limit, 1000..50000 px/s
  function automatic logic [15:0] clamp_cap(logic [15:0] v);
    logic [15:0] r;
    if (v < 16'd1000) begin
      r = 16'd1000;
    end else if (v > 16'd50000) begin
      r = 16'd50000;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

FILE: rtl/sstc_forecast.sv
// Four-stage forecast pipe: scroll distance over the lookahead, rounded, added to the top.
// Depends on sstc_pkg for the reciprocal constants and the fc_t result type.
module sstc_forecast (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [30:0]     top_i,
  input  logic [15:0]     mag_i,
  input  logic            neg_i,
  input  logic [9:0]      ms_i,
  output sstc_pkg::fc_t   fc_o
);

  logic        v1_q, v2_q, v3_q, v4_q;
  logic [30:0] top1_q, top2_q, top3_q, top4_q;
  logic        neg1_q, neg2_q, neg3_q;
  logic [25:0] p1_q;
  logic [27:0] x2_q;
  logic [19:0] q2_q;
  logic [19:0] shift3_q;
  logic [31:0] fore4_q;

  logic [27:0] x2_d;
  logic [48:0] prod2;
  logic [27:0] qmul3;
  logic [27:0] rem3;
  logic [19:0] shift3_d;
  logic [32:0] sum4;
  logic [31:0] fore4_d;

  // Quotient estimate of (4p + 125) / 250, at most one short
  assign x2_d  = {p1_q, 2'b00} + sstc_pkg::ROUND_BIAS;
  assign prod2 = 49'(x2_d) * 49'(sstc_pkg::RECIP_250);

  // Correct the estimate with one compare and subtract
  assign qmul3    = 28'(q2_q) * sstc_pkg::DIV_250;
  assign rem3     = x2_q - qmul3;
  assign shift3_d = q2_q + 20'(rem3 >= sstc_pkg::DIV_250);

  // Apply the signed shift and floor at zero
  assign sum4    = neg3_q ? ({2'b00, top3_q} - {13'd0, shift3_q})
                          : ({2'b00, top3_q} + {13'd0, shift3_q});
  assign fore4_d = sum4[32] ? 32'd0 : sum4[31:0];

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  // Advance data
  always_ff @(posedge clk_i) begin
    p1_q     <= 26'(mag_i * ms_i);
    top1_q   <= top_i;
    neg1_q   <= neg_i;
    x2_q     <= x2_d;
    q2_q     <= prod2[47:28];
    top2_q   <= top1_q;
    neg2_q   <= neg1_q;
    shift3_q <= shift3_d;
    top3_q   <= top2_q;
    neg3_q   <= neg2_q;
    fore4_q  <= fore4_d;
    top4_q   <= top3_q;
  end

  assign fc_o.valid = v4_q;
  assign fc_o.top   = top4_q;
  assign fc_o.fore  = fore4_q;

endmodule

FILE: rtl/sstc_widen.sv
// Two-stage widening unit: span times height, then times direction bias, rounded.
// Depends on sstc_pkg for the bias constants and the widen_t result type.
module sstc_widen (
  input  logic             clk_i,
  input  logic [7:0]       hot_i,
  input  logic [8:0]       warm_i,
  input  logic [19:0]      height_i,
  input  logic             fwd_i,
  output sstc_pkg::widen_t wid_o
);

  logic [27:0] hh_q;
  logic [28:0] wh_q;
  logic        fwd_q;
  logic [8:0]  bias_end;
  logic [8:0]  bias_start;
  logic [37:0] hot_lo_p, hot_hi_p, warm_lo_p, warm_hi_p;
  sstc_pkg::widen_t wid_d, wid_q;

  // Span times viewport height
  always_ff @(posedge clk_i) begin
    hh_q  <= 28'(hot_i * height_i);
    wh_q  <= 29'(warm_i * height_i);
    fwd_q <= fwd_i;
  end

  // Scroll direction gets the larger bias
  assign bias_end   = fwd_q ? sstc_pkg::BIAS_FWD : sstc_pkg::BIAS_BACK;
  assign bias_start = fwd_q ? sstc_pkg::BIAS_BACK : sstc_pkg::BIAS_FWD;

  // Scale by bias, round half up, drop 12 fraction bits
  assign hot_lo_p  = 38'(hh_q) * 38'(bias_start) + 38'd2048;
  assign hot_hi_p  = 38'(hh_q) * 38'(bias_end) + 38'd2048;
  assign warm_lo_p = 38'(wh_q) * 38'(bias_start) + 38'd2048;
  assign warm_hi_p = 38'(wh_q) * 38'(bias_end) + 38'd2048;

  assign wid_d.hot_lo  = hot_lo_p[37:12];
  assign wid_d.hot_hi  = hot_hi_p[37:12];
  assign wid_d.warm_lo = warm_lo_p[37:12];
  assign wid_d.warm_hi = warm_hi_p[37:12];

  always_ff @(posedge clk_i) begin
    wid_q <= wid_d;
  end

  assign wid_o = wid_q;

endmodule

FILE: rtl/scroll_segment_tier_classifier.sv
// Scroll segment tier classifier, top level: input stage, forecast and widening pipes,
// range and classify stages. Uses sstc_pkg, sstc_forecast and sstc_widen.
// done_o follows start_i through 7 register stages: input, forecast pipe, range and output stages.
// Throughput: one word per cycle; busy_o is never raised and results cannot be held off.
// Reset clears the valid chain and loads the register defaults; no pipeline flush needed.
module scroll_segment_tier_classifier (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [31:0]                 view_top_i,
  input  logic [19:0]                        view_height_i,
  input  logic signed [17:0]                 scroll_speed_i,
  input  logic signed [31:0]                 seg_top_i,
  input  logic [23:0]                        seg_height_i,
  input  logic                               cfg_we_i,
  input  logic [sstc_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [sstc_pkg::CfgDataW-1:0]      cfg_data_i,
  output logic                               done_o,
  output logic [1:0]                         tier_o,
  output logic [33:0]                        hot_from_o,
  output logic [33:0]                        hot_to_o,
  output logic [33:0]                        warm_from_o,
  output logic [33:0]                        warm_to_o,
  output logic [33:0]                        forecast_top_o
);

  localparam int unsigned Dly = 4;

  // Configuration registers
  logic [7:0]  cfg_hot_q;
  logic [9:0]  cfg_warm_q;
  logic [11:0] cfg_ms_q;
  logic [15:0] cfg_cap_q;
  logic [7:0]  hot_c;
  logic [8:0]  warm_c;
  logic [9:0]  ms_c;
  logic [15:0] cap_c;

  // Input stage
  logic               v0_q;
  logic [30:0]        top0_q;
  logic [19:0]        hgt0_q;
  logic [15:0]        mag0_q;
  logic               neg0_q;
  logic signed [31:0] stop0_q;
  logic signed [32:0] sbot0_q;
  logic [17:0]        speed_abs;
  logic [19:0]        hgt_d;
  logic [23:0]        shgt_d;

  // Delay lines to the range stage
  logic [19:0]        hgt_dly_q  [Dly];
  logic signed [31:0] stop_dly_q [Dly];
  logic signed [32:0] sbot_dly_q [Dly];
  sstc_pkg::widen_t   wid2, wid3_q, wid4_q;
  sstc_pkg::fc_t      fc4;

  // Range stage
  logic               v5_q;
  logic [33:0]        hot_from5_q, hot_to5_q, warm_from5_q, warm_to5_q, fore5_q;
  logic signed [31:0] stop5_q;
  logic signed [32:0] sbot5_q;
  logic [31:0]        a0;
  logic [32:0]        a1;
  logic [32:0]        hot_diff, warm_diff;
  logic [33:0]        hot_from_d, hot_to_d, warm_from_d, warm_to_d;

  // Output stage
  logic               done_q;
  sstc_pkg::tier_e    tier_d, tier_q;
  logic [33:0]        hot_from_q, hot_to_q, warm_from_q, warm_to_q, fore_q;
  logic signed [34:0] s_top, s_bot;
  logic               in_hot, in_warm;

  assign busy_o = 1'b0;

  // Hold register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_hot_q  <= sstc_pkg::HOT_RESET;
      cfg_warm_q <= sstc_pkg::WARM_RESET;
      cfg_ms_q   <= sstc_pkg::MS_RESET;
      cfg_cap_q  <= sstc_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      case (sstc_pkg::cfg_idx_e'(cfg_idx_i))
        sstc_pkg::CFG_HOT_SPAN:  cfg_hot_q  <= cfg_data_i[7:0];
        sstc_pkg::CFG_WARM_SPAN: cfg_warm_q <= cfg_data_i[9:0];
        sstc_pkg::CFG_LOOKAHEAD: cfg_ms_q   <= cfg_data_i[11:0];
        sstc_pkg::CFG_SPEED_CAP: cfg_cap_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign hot_c  = sstc_pkg::clamp_hot(cfg_hot_q);
  assign warm_c = sstc_pkg::clamp_warm(cfg_warm_q);
  assign ms_c   = sstc_pkg::clamp_ms(cfg_ms_q);
  assign cap_c  = sstc_pkg::clamp_cap(cfg_cap_q);

  // Condition the input word
  assign speed_abs = scroll_speed_i[17] ? (18'd0 - scroll_speed_i) : scroll_speed_i;
  assign hgt_d     = (view_height_i < 20'd16) ? 20'd16 : view_height_i;
  assign shgt_d    = (seg_height_i < 24'd16) ? 24'd16 : seg_height_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else begin
      v0_q <= start_i & ~busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    top0_q  <= view_top_i[31] ? 31'd0 : view_top_i[30:0];
    hgt0_q  <= hgt_d;
    mag0_q  <= (speed_abs > {2'b00, cap_c}) ? cap_c : speed_abs[15:0];
    neg0_q  <= scroll_speed_i[17];
    stop0_q <= seg_top_i;
    sbot0_q <= 33'(seg_top_i) + $signed({9'd0, shgt_d});
  end

  sstc_forecast u_forecast (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .top_i   (top0_q),
    .mag_i   (mag0_q),
    .neg_i   (neg0_q),
    .ms_i    (ms_c),
    .fc_o    (fc4)
  );

  sstc_widen u_widen (
    .clk_i    (clk_i),
    .hot_i    (hot_c),
    .warm_i   (warm_c),
    .height_i (hgt0_q),
    .fwd_i    (~neg0_q),
    .wid_o    (wid2)
  );

  // Align height, segment and widening with the forecast
  always_ff @(posedge clk_i) begin
    hgt_dly_q[0]  <= hgt0_q;
    stop_dly_q[0] <= stop0_q;
    sbot_dly_q[0] <= sbot0_q;
    for (int i = 1; i < Dly; i++) begin
      hgt_dly_q[i]  <= hgt_dly_q[i-1];
      stop_dly_q[i] <= stop_dly_q[i-1];
      sbot_dly_q[i] <= sbot_dly_q[i-1];
    end
    wid3_q <= wid2;
    wid4_q <= wid3_q;
  end

  // Build the hot and warm ranges around the viewport union
  assign a0 = ({1'b0, fc4.top} < fc4.fore) ? {1'b0, fc4.top} : fc4.fore;
  assign a1 = (({1'b0, fc4.top} > fc4.fore) ? {2'b00, fc4.top} : {1'b0, fc4.fore})
              + {13'd0, hgt_dly_q[Dly-1]};

  assign hot_diff    = {1'b0, a0} - {7'd0, wid4_q.hot_lo};
  assign warm_diff   = {1'b0, a0} - {7'd0, wid4_q.warm_lo};
  assign hot_from_d  = hot_diff[32] ? 34'd0 : {2'b00, hot_diff[31:0]};
  assign warm_from_d = warm_diff[32] ? 34'd0 : {2'b00, warm_diff[31:0]};
  assign hot_to_d    = {1'b0, a1} + {8'd0, wid4_q.hot_hi};
  assign warm_to_d   = {1'b0, a1} + {8'd0, wid4_q.warm_hi};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= fc4.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    hot_from5_q  <= hot_from_d;
    hot_to5_q    <= hot_to_d;
    warm_from5_q <= warm_from_d;
    warm_to5_q   <= warm_to_d;
    fore5_q      <= {2'b00, fc4.fore};
    stop5_q      <= stop_dly_q[Dly-1];
    sbot5_q      <= sbot_dly_q[Dly-1];
  end

  // Classify by closed-interval overlap, hot first
  assign s_top   = 35'(stop5_q);
  assign s_bot   = 35'(sbot5_q);
  assign in_hot  = ($signed({1'b0, hot_to5_q}) >= s_top) &&
                   ($signed({1'b0, hot_from5_q}) <= s_bot);
  assign in_warm = ($signed({1'b0, warm_to5_q}) >= s_top) &&
                   ($signed({1'b0, warm_from5_q}) <= s_bot);

  always_comb begin
    if (in_hot) begin
      tier_d = sstc_pkg::TIER_HOT;
    end else if (in_warm) begin
      tier_d = sstc_pkg::TIER_WARM;
    end else begin
      tier_d = sstc_pkg::TIER_COLD;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    tier_q      <= tier_d;
    hot_from_q  <= hot_from5_q;
    hot_to_q    <= hot_to5_q;
    warm_from_q <= warm_from5_q;
    warm_to_q   <= warm_to5_q;
    fore_q      <= fore5_q;
  end

  assign done_o         = done_q;
  assign tier_o         = tier_q;
  assign hot_from_o     = hot_from_q;
  assign hot_to_o       = hot_to_q;
  assign warm_from_o    = warm_from_q;
  assign warm_to_o      = warm_to_q;
  assign forecast_top_o = fore_q;

  // Every result traces back to a word taken at the input stage
  a_done_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, 7))
    else $error("result without a matching start");

  // The forecast top lies inside the hot range and at or past the warm start
  a_fore_in_hot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hot_from_o <= forecast_top_o) && (hot_to_o > forecast_top_o) &&
               (warm_from_o <= forecast_top_o))
    else $error("forecast top outside hot range");

endmodule

FILE: test/tb_scroll_segment_tier_classifier.sv
// Testbench for scroll_segment_tier_classifier: drives viewport/segment words, predicts each
// verdict in a behavioral model and checks every result field. Depends on sstc_pkg and the RTL.
`timescale 1ns / 1ps

module tb_scroll_segment_tier_classifier;

  localparam int unsigned PipeDepth  = 7;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandPhases = 8;
  localparam int unsigned PhaseWords = 100;

  // One viewport/segment request
  typedef struct packed {
    logic signed [31:0] view_top;
    logic [19:0]        view_height;
    logic signed [17:0] scroll_speed;
    logic signed [31:0] seg_top;
    logic [23:0]        seg_height;
  } seg_query_t;

  // One classification with its range bounds
  typedef struct packed {
    sstc_pkg::tier_e tier;
    logic [33:0]     hot_from;
    logic [33:0]     hot_to;
    logic [33:0]     warm_from;
    logic [33:0]     warm_to;
    logic [33:0]     forecast_top;
  } seg_verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start_i = 1'b0;
  logic busy_o;
  logic signed [31:0] view_top_i = '0;
  logic [19:0] view_height_i = '0;
  logic signed [17:0] scroll_speed_i = '0;
  logic signed [31:0] seg_top_i = '0;
  logic [23:0] seg_height_i = '0;
  logic cfg_we_i = 1'b0;
  logic [sstc_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [sstc_pkg::CfgDataW-1:0] cfg_data_i = '0;
  logic done_o;
  logic [1:0] tier_o;
  logic [33:0] hot_from_o, hot_to_o, warm_from_o, warm_to_o, forecast_top_o;

  // Register copies used for prediction
  logic [7:0]  hot_span_r;
  logic [9:0]  warm_span_r;
  logic [11:0] lookahead_r;
  logic [15:0] speed_cap_r;

  seg_query_t   query_q[$];
  seg_verdict_t verdict_q[$];
  int unsigned  idle_pct = 0;
  int unsigned  queued_total = 0;
  int unsigned  checked_total = 0;
  int unsigned  fail_count = 0;
  int unsigned  cycle_count = 0;
  logic         took_word = 1'b0;

  scroll_segment_tier_classifier DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .view_top_i     (view_top_i),
    .view_height_i  (view_height_i),
    .scroll_speed_i (scroll_speed_i),
    .seg_top_i      (seg_top_i),
    .seg_height_i   (seg_height_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .done_o         (done_o),
    .tier_o         (tier_o),
    .hot_from_o     (hot_from_o),
    .hot_to_o       (hot_to_o),
    .warm_from_o    (warm_from_o),
    .warm_to_o      (warm_to_o),
    .forecast_top_o (forecast_top_o)
  );

  initial forever #2 clk_i = ~clk_i;

  function automatic longint limit(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Range growth in Q.4: screens * height * bias / 4096, ties round up
  function automatic longint widen_by(longint screens, longint height, longint bias);
    return (screens * height * bias + 2048) / 4096;
  endfunction

  // Forecast the viewport, build hot/warm ranges and classify the segment
  function automatic seg_verdict_t classify_segment(seg_query_t q);
    seg_verdict_t v;
    longint hot, warm, ms, cap, top, ht, spd, stop, sbot, prod, shift, fore;
    longint fwd, back, a0, a1, hf, hto, wf, wto;
    hot  = limit(longint'(hot_span_r), 8, 128);
    warm = limit(longint'(warm_span_r), 32, 480);
    ms   = limit(longint'(lookahead_r), 0, 1000);
    cap  = limit(longint'(speed_cap_r), 1000, 50000);
    top  = longint'(q.view_top);
    if (top < 0) top = 0;
    ht = longint'(q.view_height);
    if (ht < 16) ht = 16;
    stop = longint'(q.seg_top);
    sbot = longint'(q.seg_height);
    if (sbot < 16) sbot = 16;
    sbot = stop + sbot;
    spd = limit(longint'(q.scroll_speed), -cap, cap);
    // shift in Q.4, rounded half away from zero
    prod  = spd * ms * 16;
    shift = ((prod < 0 ? -prod : prod) + 500) / 1000;
    if (prod < 0) shift = -shift;
    fore = top + shift;
    if (fore < 0) fore = 0;
    fwd  = (spd >= 0) ? longint'(sstc_pkg::BIAS_FWD) : longint'(sstc_pkg::BIAS_BACK);
    back = (spd >= 0) ? longint'(sstc_pkg::BIAS_BACK) : longint'(sstc_pkg::BIAS_FWD);
    a0 = (top < fore) ? top : fore;
    a1 = ((top > fore) ? top : fore) + ht;
    hf  = a0 - widen_by(hot, ht, back);
    hto = a1 + widen_by(hot, ht, fwd);
    wf  = a0 - widen_by(warm, ht, back);
    wto = a1 + widen_by(warm, ht, fwd);
    if (hf < 0) hf = 0;
    if (wf < 0) wf = 0;
    if (sbot >= hf && stop <= hto) begin
      v.tier = sstc_pkg::TIER_HOT;
    end else if (sbot >= wf && stop <= wto) begin
      v.tier = sstc_pkg::TIER_WARM;
    end else begin
      v.tier = sstc_pkg::TIER_COLD;
    end
    v.hot_from     = hf[33:0];
    v.hot_to       = hto[33:0];
    v.warm_from    = wf[33:0];
    v.warm_to      = wto[33:0];
    v.forecast_top = fore[33:0];
    return v;
  endfunction

  // Place the segment on a range bound: nudge 0 touches it, positive nudge misses outward
  function automatic seg_query_t aim_at_bound(seg_query_t q, int unsigned bound, int nudge);
    seg_verdict_t v;
    longint span, mark;
    v = classify_segment(q);
    span = (q.seg_height < 16) ? 16 : longint'(q.seg_height);
    case (bound)
      0: mark = longint'(v.hot_from) - span - nudge;
      1: mark = longint'(v.hot_to) + nudge;
      2: mark = longint'(v.warm_from) - span - nudge;
      default: mark = longint'(v.warm_to) + nudge;
    endcase
    q.seg_top = mark[31:0];
    return q;
  endfunction

  function automatic seg_query_t make_query(logic [31:0] top, logic [19:0] height,
                                            logic [17:0] speed, logic [31:0] stop,
                                            logic [23:0] sheight);
    seg_query_t q;
    q.view_top     = top;
    q.view_height  = height;
    q.scroll_speed = speed;
    q.seg_top      = stop;
    q.seg_height   = sheight;
    return q;
  endfunction

  // Mostly segments near the viewport or on a range bound, some fully random
  function automatic seg_query_t random_query();
    seg_query_t q;
    longint off;
    int unsigned pick;
    int nudge;
    pick = $urandom_range(0, 9);
    q.view_top = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 32'h0100_0000);
    case ($urandom_range(0, 7))
      0: q.view_height = 20'($urandom_range(0, 15));
      1: q.view_height = 20'($urandom);
      default: q.view_height = 20'($urandom_range(2000, 20000));
    endcase
    case ($urandom_range(0, 3))
      0: q.scroll_speed = 18'($urandom);
      1: q.scroll_speed = 18'($urandom_range(0, 200) - 100);
      default: q.scroll_speed = 18'($urandom_range(0, 120000) - 60000);
    endcase
    case ($urandom_range(0, 7))
      0: q.seg_height = 24'($urandom_range(0, 15));
      1: q.seg_height = 24'($urandom);
      default: q.seg_height = 24'($urandom_range(16, 40000));
    endcase
    q.seg_top = '0;
    if (pick == 0) begin
      q.seg_top = $urandom;
    end else if (pick <= 5) begin
      off = longint'(q.view_top) +
            (longint'($urandom_range(0, 160)) - 80) * longint'(q.view_height) / 4;
      q.seg_top = off[31:0];
    end else begin
      nudge = int'($urandom_range(0, 2)) - 1;
      q = aim_at_bound(q, $urandom_range(0, 3), nudge);
    end
    return q;
  endfunction

  task automatic enqueue(seg_query_t q);
    query_q.push_back(q);
    queued_total++;
  endtask

  task automatic check_field(string name, logic [33:0] want, logic [33:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Write one register at a falling edge, drop the enable at the next falling edge
  task automatic write_reg(sstc_pkg::cfg_idx_e idx, logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Hold until every queued word has been answered, then let the pipe settle
  task automatic wait_idle();
    wait (checked_total == queued_total);
    repeat (PipeDepth + 3) @(negedge clk_i);
  endtask

  // Driver: present the next word at the falling edge, idling at random
  always @(negedge clk_i) begin : drive_words
    seg_query_t q;
    if (start_i && !took_word) begin
      // hold the current word until it is taken
    end else if (query_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
      q = query_q.pop_front();
      start_i        <= 1'b1;
      view_top_i     <= q.view_top;
      view_height_i  <= q.view_height;
      scroll_speed_i <= q.scroll_speed;
      seg_top_i      <= q.seg_top;
      seg_height_i   <= q.seg_height;
    end else begin
      start_i <= 1'b0;
    end
  end

  // Monitor: check results, track register writes, predict each taken word
  always @(posedge clk_i) begin : watch_words
    seg_verdict_t want;
    seg_query_t q;
    if (!rst_ni) begin
      hot_span_r  = sstc_pkg::HOT_RESET;
      warm_span_r = sstc_pkg::WARM_RESET;
      lookahead_r = sstc_pkg::MS_RESET;
      speed_cap_r = sstc_pkg::CAP_RESET;
      took_word  <= 1'b0;
    end else begin
      if (done_o) begin
        if (verdict_q.size() == 0) begin
          $error("result with no word outstanding: tier %0d", tier_o);
          fail_count++;
        end else begin
          want = verdict_q.pop_front();
          check_field("tier", 34'(want.tier), 34'(tier_o));
          check_field("hot_from", want.hot_from, hot_from_o);
          check_field("hot_to", want.hot_to, hot_to_o);
          check_field("warm_from", want.warm_from, warm_from_o);
          check_field("warm_to", want.warm_to, warm_to_o);
          check_field("forecast_top", want.forecast_top, forecast_top_o);
          checked_total++;
        end
      end
      if (cfg_we_i) begin
        case (sstc_pkg::cfg_idx_e'(cfg_idx_i))
          sstc_pkg::CFG_HOT_SPAN:  hot_span_r  = cfg_data_i[7:0];
          sstc_pkg::CFG_WARM_SPAN: warm_span_r = cfg_data_i[9:0];
          sstc_pkg::CFG_LOOKAHEAD: lookahead_r = cfg_data_i[11:0];
          sstc_pkg::CFG_SPEED_CAP: speed_cap_r = cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (start_i && !busy_o) begin
        q = make_query(view_top_i, view_height_i, scroll_speed_i, seg_top_i, seg_height_i);
        verdict_q.push_back(classify_segment(q));
      end
      took_word <= start_i && !busy_o;
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin : run_phases
    seg_query_t base;
    logic [15:0] hot_d, warm_d, ms_d, cap_d;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed words under the reset settings
    enqueue(make_query(32'd0, 20'd0, 18'd0, 32'd0, 24'd0));
    enqueue(make_query(32'h7FFF_FFFF, 20'hFFFFF, 18'h1FFFF, 32'h7FFF_FFFF, 24'hFFFFFF));
    enqueue(make_query(32'h8000_0000, 20'd0, 18'h20000, 32'h8000_0000, 24'd0));
    // negative segment reaching zero, then one wholly below zero
    enqueue(make_query(32'd0, 20'd16000, 18'd0, -32'sd32, 24'd64));
    enqueue(make_query(32'd5000000, 20'd16000, 18'd0, -32'sd200, 24'd16));
    // forecast pulled below zero
    enqueue(make_query(32'd1600, 20'd16000, 18'h20000, 32'd100000, 24'd1600));
    // direction flips around zero speed and at the speed cap
    enqueue(make_query(32'd160000, 20'd16000, -18'sd1, 32'd160000, 24'd1600));
    enqueue(make_query(32'd160000, 20'd16000, 18'd1, 32'd160000, 24'd1600));
    enqueue(make_query(32'd160000, 20'd16000, 18'd10000, 32'd200000, 24'd1600));
    enqueue(make_query(32'd160000, 20'd16000, -18'sd10001, 32'd200000, 24'd1600));
    enqueue(make_query(32'd160000, 20'd15, 18'd10001, 32'd160000, 24'd15));
    // segment touching and just missing each range bound
    base = make_query(32'd1600000, 20'd16000, 18'd3000, 32'd0, 24'd1600);
    for (int unsigned b = 0; b < 4; b++) begin
      enqueue(aim_at_bound(base, b, 0));
      enqueue(aim_at_bound(base, b, 1));
    end

    // Random words over several settings; pause for a full drain before each write
    for (int unsigned ph = 0; ph < RandPhases; ph++) begin
      wait_idle();
      case (ph)
        0: begin hot_d = 16'd0;     warm_d = 16'd0;     ms_d = 16'd0;     cap_d = 16'd0;     end
        1: begin hot_d = 16'd255;   warm_d = 16'd1023;  ms_d = 16'd4095;  cap_d = 16'hFFFF; end
        2: begin hot_d = 16'd8;     warm_d = 16'd32;    ms_d = 16'd1000;  cap_d = 16'd1000;  end
        3: begin hot_d = 16'd128;   warm_d = 16'd480;   ms_d = 16'd1000;  cap_d = 16'd50000; end
        4: begin hot_d = 16'hFFFF;  warm_d = 16'hFFFF;  ms_d = 16'hFFFF;  cap_d = 16'd49999; end
        default: begin
          hot_d  = 16'($urandom);
          warm_d = 16'($urandom);
          ms_d   = 16'($urandom);
          cap_d  = 16'($urandom);
        end
      endcase
      write_reg(sstc_pkg::CFG_HOT_SPAN, hot_d);
      write_reg(sstc_pkg::CFG_WARM_SPAN, warm_d);
      write_reg(sstc_pkg::CFG_LOOKAHEAD, ms_d);
      write_reg(sstc_pkg::CFG_SPEED_CAP, cap_d);
      @(negedge clk_i);
      idle_pct = (ph < 3) ? 15 : (ph < 6) ? 72 : 0;
      for (int unsigned n = 0; n < PhaseWords; n++) enqueue(random_query());
    end

    wait_idle();
    if (fail_count == 0 && verdict_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
